// ===== rtl/fat12_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster table package
// Shared codes, constants, types and entry packing helpers for the FAT12
// cluster table engine.
// ----------------------------------------------------------------------------
package fat12_pkg;

   // Operation codes carried in the mode field.
   localparam logic [2:0] MODE_LOAD  = 3'd0;
   localparam logic [2:0] MODE_READ  = 3'd1;
   localparam logic [2:0] MODE_NEXT  = 3'd2;
   localparam logic [2:0] MODE_SET   = 3'd3;
   localparam logic [2:0] MODE_ALLOC = 3'd4;
   localparam logic [2:0] MODE_FREE  = 3'd5;

   // Status codes of a result word.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_LOOP = 2'd2;

   // Entry values and cluster limits.
   localparam logic [11:0] ENTRY_FREE    = 12'h000;
   localparam logic [11:0] ENTRY_EOC     = 12'hFFF;
   localparam logic [11:0] ENTRY_RSV_MIN = 12'hFF8;
   localparam logic [11:0] CLUSTER_FIRST = 12'd2;
   localparam logic [12:0] LIMIT_RESET   = 13'd2849;
   localparam logic [12:0] LIMIT_MAX     = 13'd4096;

   // Access to the packed table: a byte pair read and a masked byte pair write.
   typedef struct packed {
      logic [12:0] rd_addr;
      logic [12:0] wr_addr;
      logic [15:0] wr_data;
      logic [1:0]  wr_mask;
   } store_req_type;

   // One result word.
   typedef struct packed {
      logic [11:0] entry_out;
      logic [7:0]  byte_out;
      logic [12:0] freed_count;
      logic [1:0]  status;
   } result_type;

   // Byte offset of an entry: c + c/2.
   function automatic logic [12:0] ent_off(input logic [11:0] c);
      ent_off = {1'b0, c} + {2'b00, c[11:1]};
   endfunction

   // Entry value out of its little-endian byte pair.
   function automatic logic [11:0] ent_get(input logic odd, input logic [15:0] w);
      ent_get = odd ? w[15:4] : w[11:0];
   endfunction

   // Byte pair with a new entry value, keeping the neighbor's nibble.
   function automatic logic [15:0] ent_merge(input logic odd, input logic [15:0] w,
                                             input logic [11:0] v);
      ent_merge = odd ? {v, w[3:0]} : {w[15:12], v};
   endfunction

   // Cluster that continues a chain.
   function automatic logic in_chain(input logic [11:0] c);
      in_chain = (c >= CLUSTER_FIRST) && (c < ENTRY_RSV_MIN);
   endfunction

endpackage

// ===== rtl/fat12_req_if.sv =====
// ----------------------------------------------------------------------------
// FAT12 request channel
// Valid/ready channel that carries one operation word into the engine.
// ----------------------------------------------------------------------------
interface fat12_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [11:0] cluster;
   logic [11:0] entry_in;
   logic [12:0] byte_index;
   logic [7:0]  byte_in;

   modport source (output valid, mode, cluster, entry_in, byte_index, byte_in,
                   input ready);
   modport sink (input valid, mode, cluster, entry_in, byte_index, byte_in,
                 output ready);
endinterface

// ===== rtl/fat12_rsp_if.sv =====
// ----------------------------------------------------------------------------
// FAT12 response channel
// Valid/ready channel that carries one result word out of the engine.
// ----------------------------------------------------------------------------
interface fat12_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] entry_out;
   logic [7:0]  byte_out;
   logic [12:0] freed_count;
   logic [1:0]  status;

   modport source (output valid, entry_out, byte_out, freed_count, status,
                   input ready);
   modport sink (input valid, entry_out, byte_out, freed_count, status,
                 output ready);
endinterface

// ===== rtl/fat12_store.sv =====
// ----------------------------------------------------------------------------
// FAT12 table store
// Packed table held in an even and an odd byte bank, so that any byte pair
// is read or written with one access to each bank. Read data is registered;
// a write in the same cycle as a read of an overlapping byte is forwarded.
// ----------------------------------------------------------------------------
module fat12_store
   import fat12_pkg::*;
#(
   parameter int TABLE_BYTES = 6144
) (
   input  logic          clock,
   input  logic          reset,
   input  store_req_type sreq,
   output logic [15:0]   rd_data
);

   localparam int          BANK_DEPTH = (TABLE_BYTES + 1) / 2;
   localparam int          ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam logic [13:0] TB_LIMIT   = 14'(TABLE_BYTES);

   logic [7:0] mem_even [BANK_DEPTH];
   logic [7:0] mem_odd  [BANK_DEPTH];

   logic [13:0] ra0, ra1, wa0, wa1;
   logic [13:0] er_addr, or_addr, ew_addr, ow_addr;
   logic        we0, we1, ew_en, ow_en;
   logic [7:0]  ew_data, ow_data;
   logic [7:0]  even_q, odd_q;

   logic        sel_ff;
   logic        ok0_ff, ok1_ff;
   logic [13:0] ra0_ff, ra1_ff, wa0_ff, wa1_ff;
   logic [15:0] wd_ff;
   logic [1:0]  wm_ff, wm_in;
   logic [7:0]  b0, b1;

   // Byte addresses of the pair and their bank mapping.
   always_comb begin
      ra0     = {1'b0, sreq.rd_addr};
      ra1     = ra0 + 14'd1;
      wa0     = {1'b0, sreq.wr_addr};
      wa1     = wa0 + 14'd1;
      we0     = sreq.wr_mask[0] && (wa0 < TB_LIMIT);
      we1     = sreq.wr_mask[1] && (wa1 < TB_LIMIT);
      wm_in   = {we1, we0};
      er_addr = sreq.rd_addr[0] ? ra1 : ra0;
      or_addr = sreq.rd_addr[0] ? ra0 : ra1;
      ew_addr = sreq.wr_addr[0] ? wa1 : wa0;
      ow_addr = sreq.wr_addr[0] ? wa0 : wa1;
      ew_en   = sreq.wr_addr[0] ? we1 : we0;
      ow_en   = sreq.wr_addr[0] ? we0 : we1;
      ew_data = sreq.wr_addr[0] ? sreq.wr_data[15:8] : sreq.wr_data[7:0];
      ow_data = sreq.wr_addr[0] ? sreq.wr_data[7:0] : sreq.wr_data[15:8];
   end

   // Even bank.
   always_ff @(posedge clock) begin
      if (ew_en) begin
         mem_even[ew_addr[ROW_W:1]] <= ew_data;
      end
      even_q <= mem_even[er_addr[ROW_W:1]];
   end

   // Odd bank.
   always_ff @(posedge clock) begin
      if (ow_en) begin
         mem_odd[ow_addr[ROW_W:1]] <= ow_data;
      end
      odd_q <= mem_odd[or_addr[ROW_W:1]];
   end

   // Read and write context kept for the returning data.
   always_ff @(posedge clock) begin
      if (reset) begin
         wm_ff <= 2'b00;
      end else begin
         wm_ff <= wm_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sreq.rd_addr[0];
      ok0_ff <= ra0 < TB_LIMIT;
      ok1_ff <= ra1 < TB_LIMIT;
      ra0_ff <= ra0;
      ra1_ff <= ra1;
      wa0_ff <= wa0;
      wa1_ff <= wa1;
      wd_ff  <= sreq.wr_data;
   end

   // Bank select, write forwarding and bounds masking of the pair.
   always_comb begin
      b0 = sel_ff ? odd_q : even_q;
      b1 = sel_ff ? even_q : odd_q;
      if (wm_ff[0] && (wa0_ff == ra0_ff)) begin
         b0 = wd_ff[7:0];
      end else if (wm_ff[1] && (wa1_ff == ra0_ff)) begin
         b0 = wd_ff[15:8];
      end
      if (wm_ff[0] && (wa0_ff == ra1_ff)) begin
         b1 = wd_ff[7:0];
      end else if (wm_ff[1] && (wa1_ff == ra1_ff)) begin
         b1 = wd_ff[15:8];
      end
      rd_data = {(ok1_ff ? b1 : 8'h00), (ok0_ff ? b0 : 8'h00)};
   end

endmodule

// ===== rtl/fat12_ctrl.sv =====
// ----------------------------------------------------------------------------
// FAT12 table sequencer
// Accepts one operation word at a time and drives the table store through
// read, modify and write steps: byte access, entry access, allocation scan
// and chain free.
// ----------------------------------------------------------------------------
module fat12_ctrl
   import fat12_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   fat12_req_if.sink     req_chan,
   input  logic [12:0]   lim,
   input  logic [12:0]   bound,
   input  logic          out_free,
   output logic          out_load,
   output result_type    out_data,
   output store_req_type sreq,
   input  logic [15:0]   rd_data
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_BYTE = 8'b0000_0010,
      S_NEXT = 8'b0000_0100,
      S_SET  = 8'b0000_1000,
      S_SCAN = 8'b0001_0000,
      S_LINK = 8'b0010_0000,
      S_FREE = 8'b0100_0000,
      S_HOLD = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [11:0] cl_ff, cl_in;
   logic [11:0] ein_ff, ein_in;
   logic [11:0] c_ff, c_in;
   logic [12:0] issue_ff, issue_in;
   logic        chk_vld_ff, chk_vld_in;
   logic [12:0] fc_ff, fc_in;
   result_type  res_ff, res_in;

   logic        done;
   result_type  res;
   logic [11:0] ent;
   logic [12:0] fc_next;

   assign req_chan.ready = (state_ff == S_IDLE);

   // Next state, store access and result of the current step.
   always_comb begin
      state_in   = state_ff;
      cl_in      = cl_ff;
      ein_in     = ein_ff;
      c_in       = c_ff;
      issue_in   = issue_ff;
      chk_vld_in = chk_vld_ff;
      fc_in      = fc_ff;
      res_in     = res_ff;
      sreq       = '0;
      done       = 1'b0;
      res        = '0;
      out_load   = 1'b0;
      out_data   = res_ff;
      ent        = ent_get(c_ff[0], rd_data);
      fc_next    = fc_ff + 13'd1;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.mode)
                  MODE_LOAD: begin
                     sreq.wr_addr = req_chan.byte_index;
                     sreq.wr_data = {8'h00, req_chan.byte_in};
                     sreq.wr_mask = 2'b01;
                     done         = 1'b1;
                  end
                  MODE_READ: begin
                     sreq.rd_addr = req_chan.byte_index;
                     state_in     = S_BYTE;
                  end
                  MODE_NEXT: begin
                     sreq.rd_addr = ent_off(req_chan.cluster);
                     cl_in        = req_chan.cluster;
                     state_in     = S_NEXT;
                  end
                  MODE_SET: begin
                     sreq.rd_addr = ent_off(req_chan.cluster);
                     cl_in        = req_chan.cluster;
                     ein_in       = req_chan.entry_in;
                     state_in     = S_SET;
                  end
                  MODE_ALLOC: begin
                     cl_in      = req_chan.cluster;
                     issue_in   = {1'b0, CLUSTER_FIRST};
                     chk_vld_in = 1'b0;
                     state_in   = S_SCAN;
                  end
                  MODE_FREE: begin
                     c_in  = req_chan.cluster;
                     fc_in = '0;
                     if (!in_chain(req_chan.cluster)) begin
                        done = 1'b1;
                     end else if (bound == '0) begin
                        res.status = STATUS_LOOP;
                        done       = 1'b1;
                     end else begin
                        sreq.rd_addr = ent_off(req_chan.cluster);
                        state_in     = S_FREE;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_BYTE: begin
            res.byte_out = rd_data[7:0];
            done         = 1'b1;
         end
         S_NEXT: begin
            res.entry_out = ent_get(cl_ff[0], rd_data);
            done          = 1'b1;
         end
         S_SET: begin
            sreq.wr_addr = ent_off(cl_ff);
            sreq.wr_data = ent_merge(cl_ff[0], rd_data, ein_ff);
            sreq.wr_mask = 2'b11;
            done         = 1'b1;
         end
         S_SCAN: begin
            // One entry checked per cycle while the next one is being read.
            if (chk_vld_ff && (ent == ENTRY_FREE)) begin
               sreq.wr_addr = ent_off(c_ff);
               sreq.wr_data = ent_merge(c_ff[0], rd_data, ENTRY_EOC);
               sreq.wr_mask = 2'b11;
               if (cl_ff != '0) begin
                  sreq.rd_addr = ent_off(cl_ff);
                  state_in     = S_LINK;
               end else begin
                  res.entry_out = c_ff;
                  done          = 1'b1;
               end
            end else if (issue_ff < lim) begin
               sreq.rd_addr = ent_off(issue_ff[11:0]);
               c_in         = issue_ff[11:0];
               chk_vld_in   = 1'b1;
               issue_in     = issue_ff + 13'd1;
            end else begin
               res.status = STATUS_FULL;
               done       = 1'b1;
            end
         end
         S_LINK: begin
            sreq.wr_addr  = ent_off(cl_ff);
            sreq.wr_data  = ent_merge(cl_ff[0], rd_data, c_ff);
            sreq.wr_mask  = 2'b11;
            res.entry_out = c_ff;
            done          = 1'b1;
         end
         S_FREE: begin
            // Clear the current entry and read the next one in the same cycle.
            if (ent == ENTRY_FREE) begin
               res.freed_count = fc_ff;
               res.status      = STATUS_LOOP;
               done            = 1'b1;
            end else begin
               sreq.wr_addr = ent_off(c_ff);
               sreq.wr_data = ent_merge(c_ff[0], rd_data, ENTRY_FREE);
               sreq.wr_mask = 2'b11;
               fc_in        = fc_next;
               c_in         = ent;
               if (!in_chain(ent)) begin
                  res.freed_count = fc_next;
                  done            = 1'b1;
               end else if (fc_next >= bound) begin
                  res.freed_count = fc_next;
                  res.status      = STATUS_LOOP;
                  done            = 1'b1;
               end else begin
                  sreq.rd_addr = ent_off(ent);
               end
            end
         end
         S_HOLD: begin
            out_load = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hand the finished word to the output register, or park it.
      if (done) begin
         if (out_free) begin
            out_load = 1'b1;
            out_data = res;
            state_in = S_IDLE;
         end else begin
            res_in   = res;
            state_in = S_HOLD;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   // Operands and the parked result.
   always_ff @(posedge clock) begin
      cl_ff    <= cl_in;
      ein_ff   <= ein_in;
      c_ff     <= c_in;
      issue_ff <= issue_in;
      fc_ff    <= fc_in;
      res_ff   <= res_in;
   end

   // A word is only pushed into a free output register.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result pushed into an occupied output register");

   // A parked result never touches the table.
   a_hold_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> (sreq.wr_mask == 2'b00))
      else $error("table written while a result is parked");

   // The allocation scan never checks the reserved clusters.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && chk_vld_ff) |-> (c_ff >= CLUSTER_FIRST))
      else $error("allocation scan checked a reserved cluster");

endmodule

// ===== rtl/fat12_cluster_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster table engine
// Packed FAT12 allocation table with byte load and read-back, chain lookup,
// entry set, first-fit allocation and chain free.
// ----------------------------------------------------------------------------
// The table sits in two synchronous byte banks with a registered read, and
// every operation works one word at a time. Load byte and the unused modes
// finish in the step that accepts them; read byte, get next and set entry
// read first, then give the result or write back. Allocate scans from
// cluster 2, marks the first free entry end of chain and, when a previous
// cluster is given, links it to the new one; the scan reads one entry per
// cycle through the memory read port. Free chain clears each entry that it
// visits, each cleared entry being written while the next link is read;
// a walk that ends on a free entry reads that entry without clearing it.
// The table contents are undefined after reset and must be loaded before
// entry operations; no clearing pass runs. The cluster limit register may
// be written only while the block is idle. A finished word waits in the
// output register while the next word is accepted.
// ----------------------------------------------------------------------------
module fat12_cluster_table_engine_unit
   import fat12_pkg::*;
#(
   parameter int TABLE_BYTES = 6144
) (
   input  logic        clock,
   input  logic        reset,
   fat12_req_if.sink   req_chan,
   fat12_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);

   logic [12:0]   limit_ff;
   logic [12:0]   lim, bound;
   logic          rsp_valid_ff;
   result_type    rsp_data_ff;
   logic          out_free, out_load;
   result_type    out_data;
   store_req_type sreq;
   logic [15:0]   rd_data;

   // Cluster limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Effective limit and the free-chain bound.
   assign lim   = (limit_ff > LIMIT_MAX) ? LIMIT_MAX : limit_ff;
   assign bound = (lim > 13'd2) ? (lim - 13'd2) : 13'd0;

   // Output register.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.entry_out   = rsp_data_ff.entry_out;
   assign rsp_chan.byte_out    = rsp_data_ff.byte_out;
   assign rsp_chan.freed_count = rsp_data_ff.freed_count;
   assign rsp_chan.status      = rsp_data_ff.status;

   fat12_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .lim      (lim),
      .bound    (bound),
      .out_free (out_free),
      .out_load (out_load),
      .out_data (out_data),
      .sreq     (sreq),
      .rd_data  (rd_data)
   );

   fat12_store #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .sreq    (sreq),
      .rd_data (rd_data)
   );

endmodule

// ===== tb/fat12_cluster_table_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT12 cluster table engine testbench
// Loads the low area of the packed table, which holds every entry that the
// run reads, plus the few high bytes that the directed words touch, then runs
// a short directed sequence over the edge cases and a long random mix of
// allocation chains, chain walks, chain frees, entry and byte accesses under
// several cluster limits. Stimulus never reads a byte that was not loaded.
// A mirror of the table predicts every result word. The result words are
// checked in order, field by field. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module fat12_cluster_table_engine_unit_tb;
   import fat12_pkg::*;

   localparam int TABLE_SIZE    = 6144;
   localparam int STALL_LIMIT   = 20000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int PHASE_WORDS   = 108;
   localparam int AREA_BYTES    = 384;
   localparam int AREA_CLUSTERS = 256;

   // Modes that the block does not use; they must answer with an all-zero word.
   localparam logic [2:0] MODE_RSVD_A = 3'd6;
   localparam logic [2:0] MODE_RSVD_B = 3'd7;

   // Previous cluster value that means no link on allocate.
   localparam logic [11:0] NO_CLUSTER     = 12'd0;
   localparam logic [12:0] BYTE_INDEX_TOP = 13'h1FFF;

   // Cluster limits in the order the random phases use them.
   localparam logic [12:0] LIMIT_PLAN [10] = '{13'd2849, 13'd4096, 13'd40, 13'd3, 13'd2,
                                               13'd0, 13'h1FFF, 13'd1000, 13'd17, 13'd4095};

   // Mirror of the packed table; it computes the result word of each accepted
   // request word and keeps the words still owed by the block.
   class fat12_table_mirror;
      logic [7:0]  image [TABLE_SIZE];
      logic [12:0] limit_reg;
      result_type  owed_words[$];
      int unsigned mismatches;

      function new();
         limit_reg  = LIMIT_RESET;
         mismatches = 0;
      endfunction

      function void report(string what);
         mismatches++;
         $display("%0t mismatch: %s", $time, what);
      endfunction

      function void write_limit(logic [12:0] value);
         limit_reg = value;
      endfunction

      function logic [7:0] peek_byte(int unsigned idx);
         return (idx < TABLE_SIZE) ? image[idx] : 8'h00;
      endfunction

      function void poke_byte(int unsigned idx, logic [7:0] value);
         if (idx < TABLE_SIZE)
            image[idx] = value;
      endfunction

      // An entry sits at byte c + c/2 as a little-endian pair; odd entries
      // take the upper twelve bits.
      function logic [11:0] entry_at(logic [11:0] c);
         int unsigned off;
         logic [15:0] pair;
         off  = int'(c) + int'(c >> 1);
         pair = {peek_byte(off + 1), peek_byte(off)};
         return c[0] ? pair[15:4] : pair[11:0];
      endfunction

      function void entry_store(logic [11:0] c, logic [11:0] value);
         int unsigned off;
         logic [7:0] lo;
         logic [7:0] hi;
         off = int'(c) + int'(c >> 1);
         lo  = peek_byte(off);
         hi  = peek_byte(off + 1);
         if (c[0]) begin
            lo = {value[3:0], lo[3:0]};
            hi = value[11:4];
         end else begin
            lo = value[7:0];
            hi = {hi[7:4], value[11:8]};
         end
         poke_byte(off, lo);
         poke_byte(off + 1, hi);
      endfunction

      // True when an allocation now would scan past the loaded area: the
      // limit reaches beyond it and no free entry is left inside it.
      function bit scan_leaves_area();
         int unsigned lim;
         lim = (limit_reg > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(limit_reg);
         if (lim <= AREA_CLUSTERS)
            return 1'b0;
         for (int unsigned c = CLUSTER_FIRST; c < AREA_CLUSTERS; c++) begin
            if (entry_at(12'(c)) == ENTRY_FREE)
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function result_type apply_word(logic [2:0] mode, logic [11:0] cl, logic [11:0] ein,
                                      logic [12:0] bidx, logic [7:0] bin);
         result_type  r;
         int unsigned lim;
         int unsigned bound;
         logic [11:0] walk;
         logic [11:0] nx;
         r     = '0;
         lim   = (limit_reg > LIMIT_MAX) ? int'(LIMIT_MAX) : int'(limit_reg);
         bound = (lim > 2) ? lim - 2 : 0;
         case (mode)
            MODE_LOAD: poke_byte(int'(bidx), bin);
            MODE_READ: r.byte_out = peek_byte(int'(bidx));
            MODE_NEXT: r.entry_out = entry_at(cl);
            MODE_SET:  entry_store(cl, ein);
            MODE_ALLOC: begin
               // First fit from cluster 2; the new cluster ends its chain.
               r.status = STATUS_FULL;
               for (int unsigned c = CLUSTER_FIRST; c < lim; c++) begin
                  if (entry_at(12'(c)) == ENTRY_FREE) begin
                     entry_store(12'(c), ENTRY_EOC);
                     if (cl != NO_CLUSTER)
                        entry_store(cl, 12'(c));
                     r.entry_out = 12'(c);
                     r.status    = STATUS_OK;
                     break;
                  end
               end
            end
            MODE_FREE: begin
               // Walk the chain, clearing links; a zero link or too many
               // clears ends the walk as a loop.
               walk = cl;
               while (walk >= CLUSTER_FIRST && walk < ENTRY_RSV_MIN) begin
                  if (int'(r.freed_count) >= bound) begin
                     r.status = STATUS_LOOP;
                     break;
                  end
                  nx = entry_at(walk);
                  if (nx == ENTRY_FREE) begin
                     r.status = STATUS_LOOP;
                     break;
                  end
                  entry_store(walk, ENTRY_FREE);
                  r.freed_count = r.freed_count + 13'd1;
                  walk = nx;
               end
            end
            default: ;
         endcase
         owed_words.push_back(r);
         return r;
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_words.size() == 0) begin
            report($sformatf("result word with nothing owed: %h", got));
            return;
         end
         want = owed_words.pop_front();
         if (got.entry_out != want.entry_out)
            report($sformatf("entry_out %h, expected %h", got.entry_out, want.entry_out));
         if (got.byte_out != want.byte_out)
            report($sformatf("byte_out %h, expected %h", got.byte_out, want.byte_out));
         if (got.freed_count != want.freed_count)
            report($sformatf("freed_count %0d, expected %0d",
                             got.freed_count, want.freed_count));
         if (got.status != want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [12:0] csr_wr_data;

   fat12_req_if req_chan ();
   fat12_rsp_if rsp_chan ();

   fat12_table_mirror table_mirror;
   result_type        last_answer;
   int unsigned       issued = 0;
   int                idle_odds = 16;
   int                quiet_cycles = 0;
   logic [11:0]       chain_heads[$];

   fat12_cluster_table_engine_unit #(
      .TABLE_BYTES (TABLE_SIZE)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] any8();
      return 8'($urandom);
   endfunction

   function automatic logic [11:0] any12();
      return 12'($urandom);
   endfunction

   function automatic logic [12:0] any13();
      return 13'($urandom);
   endfunction

   // Any cluster whose entry lies in the loaded area.
   function automatic logic [11:0] any_cluster();
      return 12'($urandom_range(0, AREA_CLUSTERS - 1));
   endfunction

   // Idling odds; zero means no idling at all.
   function automatic int idle_choice();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 6;
         default: return 20;
      endcase
   endfunction

   // Entry values drawn evenly from free, end of chain, short links and reserved
   // values; a link always stays inside the loaded area.
   function automatic logic [11:0] entry_choice();
      case ($urandom_range(0, 3))
         0:       return ENTRY_FREE;
         1:       return ENTRY_EOC;
         2:       return 12'($urandom_range(2, AREA_CLUSTERS - 1));
         default: return ENTRY_RSV_MIN + 12'($urandom_range(0, 7));
      endcase
   endfunction

   // Initial entry values: the low clusters busy, the rest sparse.
   function automatic logic [11:0] fill_entry(int c);
      if (c < 43 || $urandom_range(0, 19) == 0)
         return entry_choice();
      return ENTRY_FREE;
   endfunction

   // Start of a chain free: a cluster in the loaded area, or a value that
   // ends the walk at once.
   function automatic logic [11:0] free_start();
      case ($urandom_range(0, 3))
         0:       return ENTRY_RSV_MIN + 12'($urandom_range(0, 7));
         default: return any_cluster();
      endcase
   endfunction

   // Send one request word, after an idle burst now and then, and note it
   // in the mirror when it is accepted.
   task automatic issue(input logic [2:0] mode, input logic [11:0] cl, input logic [11:0] ein,
                        input logic [12:0] bidx, input logic [7:0] bin);
      int unsigned gap;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.cluster    <= cl;
      req_chan.entry_in   <= ein;
      req_chan.byte_index <= bidx;
      req_chan.byte_in    <= bin;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      last_answer = table_mirror.apply_word(mode, cl, ein, bidx, bin);
      issued++;
   endtask

   // Allocate, first freeing one entry of the loaded area when the scan
   // would otherwise run past it.
   task automatic alloc(input logic [11:0] prev);
      if (table_mirror.scan_leaves_area())
         issue(MODE_SET, 12'($urandom_range(2, AREA_CLUSTERS - 1)), ENTRY_FREE,
               any13(), any8());
      issue(MODE_ALLOC, prev, any12(), any13(), any8());
   endtask

   // Write the cluster limit once the block has returned every word.
   task automatic program_limit(input logic [12:0] value);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (table_mirror.owed_words.size() != 0)
         @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      table_mirror.write_limit(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random mix; most words belong to allocated chains that are then walked
   // and freed, the rest are single operations and hand-made loops.
   task automatic random_burst(input int unsigned count, input bit calm);
      int unsigned stop_at;
      int unsigned pick;
      logic [11:0] prev;
      logic [11:0] head;
      logic [11:0] walk;
      logic [11:0] a;
      logic [11:0] b;
      stop_at = issued + count;
      while (issued < stop_at) begin
         if (!calm && $urandom_range(0, 39) == 0)
            idle_odds = idle_choice();
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            prev = ($urandom_range(0, 3) == 0) ? any_cluster() : NO_CLUSTER;
            head = NO_CLUSTER;
            repeat ($urandom_range(1, 6)) begin
               alloc(prev);
               if (last_answer.status == STATUS_OK) begin
                  if (head == NO_CLUSTER)
                     head = last_answer.entry_out;
                  prev = last_answer.entry_out;
               end
            end
            if (head != NO_CLUSTER) begin
               walk = head;
               repeat ($urandom_range(0, 3)) begin
                  if (walk < AREA_CLUSTERS) begin
                     issue(MODE_NEXT, walk, any12(), any13(), any8());
                     walk = last_answer.entry_out;
                  end
               end
               if ($urandom_range(0, 1) == 1)
                  issue(MODE_FREE, head, any12(), any13(), any8());
               else
                  chain_heads.push_back(head);
            end
         end else if (pick < 40) begin
            walk = (chain_heads.size() != 0) ? chain_heads.pop_front() : free_start();
            issue(MODE_FREE, walk, any12(), any13(), any8());
         end else if (pick < 50) begin
            issue(MODE_SET, any_cluster(), entry_choice(), any13(), any8());
         end else if (pick < 60) begin
            issue(MODE_NEXT, any_cluster(), any12(), any13(), any8());
         end else if (pick < 70) begin
            issue(MODE_READ, any12(), any12(),
                  ($urandom_range(0, 9) == 0) ? 13'($urandom_range(TABLE_SIZE, 8191))
                                              : 13'($urandom_range(0, AREA_BYTES - 1)),
                  any8());
         end else if (pick < 78) begin
            issue(MODE_LOAD, any12(), any12(), 13'($urandom_range(AREA_BYTES, 8191)), any8());
         end else if (pick < 85) begin
            alloc(($urandom_range(0, 1) == 1) ? any_cluster() : NO_CLUSTER);
         end else if (pick < 92) begin
            issue(MODE_FREE, free_start(), any12(), any13(), any8());
         end else if (pick < 96) begin
            // Two clusters pointing at each other, or one pointing at itself, then freed from one end.
            a = 12'($urandom_range(2, AREA_CLUSTERS - 1));
            b = ($urandom_range(0, 3) == 0) ? a : 12'($urandom_range(2, AREA_CLUSTERS - 1));
            issue(MODE_SET, a, b, any13(), any8());
            issue(MODE_SET, b, a, any13(), any8());
            issue(MODE_FREE, a, any12(), any13(), any8());
         end else begin
            issue(($urandom_range(0, 1) == 1) ? MODE_RSVD_A : MODE_RSVD_B,
                  any12(), any12(), any13(), any8());
         end
      end
   endtask

   // Result side: stalls in random bursts while idling is on.
   initial begin
      int unsigned burst;
      forever begin
         @(negedge clock);
         if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            burst = $urandom_range(1, 18);
            rsp_chan.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Check each accepted result word and watch for a stuck block.
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready)
         table_mirror.check_result({rsp_chan.entry_out, rsp_chan.byte_out,
                                    rsp_chan.freed_count, rsp_chan.status});
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [11:0] first_c;
      logic [11:0] second_c;
      logic [11:0] e0;
      logic [11:0] e1;
      table_mirror        = new();
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_LOAD;
      req_chan.cluster    = '0;
      req_chan.entry_in   = '0;
      req_chan.byte_index = '0;
      req_chan.byte_in    = '0;
      rsp_chan.ready      = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Load the low area three bytes at a time, one entry pair per group.
      for (int j = 0; j < AREA_BYTES / 3; j++) begin
         e0 = fill_entry(2 * j);
         e1 = fill_entry(2 * j + 1);
         issue(MODE_LOAD, any12(), any12(), 13'(3 * j), e0[7:0]);
         issue(MODE_LOAD, any12(), any12(), 13'(3 * j + 1), {e1[3:0], e0[11:8]});
         issue(MODE_LOAD, any12(), any12(), 13'(3 * j + 2), e1[11:4]);
      end

      idle_odds = 6;

      // Bytes past the end of the table and the last two bytes inside it.
      issue(MODE_LOAD, any12(), any12(), BYTE_INDEX_TOP, 8'hFF);
      issue(MODE_READ, any12(), any12(), BYTE_INDEX_TOP, any8());
      issue(MODE_LOAD, any12(), any12(), 13'(TABLE_SIZE - 2), any8());
      issue(MODE_LOAD, any12(), any12(), 13'(TABLE_SIZE - 1), 8'hFF);
      issue(MODE_READ, any12(), any12(), 13'(TABLE_SIZE - 1), any8());

      // The last entry and the two reserved low clusters.
      issue(MODE_SET, 12'hFFF, ENTRY_EOC, any13(), any8());
      issue(MODE_NEXT, 12'hFFF, any12(), any13(), any8());
      issue(MODE_SET, 12'd0, ENTRY_RSV_MIN, any13(), any8());
      issue(MODE_SET, 12'd1, ENTRY_FREE, any13(), any8());
      issue(MODE_NEXT, 12'd0, any12(), any13(), any8());
      issue(MODE_NEXT, 12'd1, any12(), any13(), any8());

      // Allocate a two-cluster chain, walk it and free it.
      alloc(NO_CLUSTER);
      first_c = last_answer.entry_out;
      alloc(first_c);
      second_c = last_answer.entry_out;
      issue(MODE_NEXT, first_c, any12(), any13(), any8());
      issue(MODE_NEXT, second_c, any12(), any13(), any8());
      issue(MODE_FREE, first_c, any12(), any13(), any8());

      // A chain that runs back into itself.
      issue(MODE_SET, 12'd100, 12'd101, any13(), any8());
      issue(MODE_SET, 12'd101, 12'd100, any13(), any8());
      issue(MODE_FREE, 12'd100, any12(), any13(), any8());

      // Start clusters outside the chain range, the end-of-chain entry and
      // a start on a free entry high in the table, whose bytes are loaded
      // first.
      issue(MODE_FREE, 12'd1, any12(), any13(), any8());
      issue(MODE_FREE, ENTRY_RSV_MIN, any12(), any13(), any8());
      issue(MODE_FREE, 12'hFFF, any12(), any13(), any8());
      issue(MODE_LOAD, any12(), any12(), 13'd4500, any8());
      issue(MODE_LOAD, any12(), any12(), 13'd4501, any8());
      issue(MODE_SET, 12'd3000, ENTRY_FREE, any13(), any8());
      issue(MODE_FREE, 12'd3000, any12(), any13(), any8());

      // Unused modes.
      issue(MODE_RSVD_A, any12(), any12(), any13(), any8());
      issue(MODE_RSVD_B, any12(), any12(), any13(), any8());

      // Random phases under each limit; the last one runs without idling.
      for (int p = 0; p < 10; p++) begin
         program_limit(LIMIT_PLAN[p]);
         idle_odds = (p == 9) ? 0 : idle_choice();
         random_burst(PHASE_WORDS, p == 9);
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (table_mirror.owed_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_mirror.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
